// ===== hw/rtl/mpfl_pkg.sv =====
// package for the multi-pool free list allocator
// field widths, parameter defaults, status codes, request/response types and fsm states
// no dependencies

package mpfl_pkg;

    localparam int IDX_W       = 10;
    localparam int POOL_W      = 4;
    localparam int POOLS_DEF   = 9;
    localparam int RECORDS_DEF = 1024;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_BAD_INDEX = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic              mode;
        logic [POOL_W-1:0] pool;
        logic [IDX_W-1:0]  freed_index;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] granted_index;
        status_t          status;
    } rsp_t;

endpackage

// ===== hw/rtl/mpfl_stream_if.sv =====
// valid/ready stream interface with a typed payload
// used for the request and response channels; no dependencies

interface mpfl_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/multi_pool_free_list_allocator.sv =====
// a response is registered when its request commits in the execute state
// no new request is taken until the last one commits; the registered link memory read
//   at the pool head sits between acceptance and the head update
// a stalled response holds the next request in the execute state until taken
// reset clears every pool head and high-water mark; the link memory is not cleared
//   and needs no clearing pass, so requests are taken right after reset
// depends on mpfl_pkg and mpfl_stream_if

module multi_pool_free_list_allocator
    import mpfl_pkg::*;
#(
    parameter int POOLS   = POOLS_DEF,
    parameter int RECORDS = RECORDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    mpfl_stream_if.sink         req,
    mpfl_stream_if.source       rsp
);

    localparam int HW    = $clog2(RECORDS + 1);
    localparam int RIW   = $clog2(RECORDS);
    localparam int PIW   = (POOLS > 1) ? $clog2(POOLS) : 1;
    localparam int LINKS = POOLS * RECORDS;
    localparam int AW    = $clog2(LINKS);
    localparam int CW    = (HW > IDX_W) ? HW : IDX_W;

    localparam logic [POOL_W:0] POOL_LIM  = (POOL_W + 1)'(POOLS);
    localparam logic [HW-1:0]   REC_LIM   = HW'(RECORDS);
    localparam logic [CW-1:0]   REC_LIM_C = CW'(RECORDS);
    localparam logic [AW-1:0]   REC_STEP  = AW'(RECORDS);

    state_t state_reg, state_next;

    logic [HW-1:0] free_head_reg  [POOLS];
    logic [HW-1:0] high_water_reg [POOLS];

    logic [HW-1:0] link_mem [LINKS];
    logic [HW-1:0] link_rd_reg;

    logic             mode_reg;
    logic             pool_ok_reg;
    logic [PIW-1:0]   pidx_reg;
    logic [IDX_W-1:0] idx_reg;

    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_data_reg, rsp_data_next;

    logic           req_fire;
    logic           pool_ok_in;
    logic [PIW-1:0] pidx_in;
    logic [HW-1:0]  head_in;
    logic [HW-1:0]  mark_in;
    logic           link_re;
    logic [AW-1:0]  link_raddr;

    logic          commit;
    logic [HW-1:0] head_cur;
    logic [HW-1:0] mark_cur;
    logic [CW-1:0] head_ext;
    logic [CW-1:0] mark_ext;
    logic [CW-1:0] idx_ext;
    logic          pool_we;
    logic [HW-1:0] head_next;
    logic [HW-1:0] mark_next;
    logic          link_we;
    logic [AW-1:0] link_waddr;

    // request side
    assign req.ready  = (state_reg == S_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign pool_ok_in = ({1'b0, req.payload.pool} < POOL_LIM);
    assign pidx_in    = pool_ok_in ? req.payload.pool[PIW-1:0] : '0;
    assign head_in    = free_head_reg[pidx_in];
    assign mark_in    = high_water_reg[pidx_in];
    assign link_re    = req_fire && pool_ok_in && (req.payload.mode == MODE_ALLOC)
                        && (head_in != mark_in);
    assign link_raddr = AW'(pidx_in) * REC_STEP + AW'(head_in[RIW-1:0]);

    // execute side
    assign commit   = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);
    assign head_cur = free_head_reg[pidx_reg];
    assign mark_cur = high_water_reg[pidx_reg];
    assign head_ext = CW'(head_cur);
    assign mark_ext = CW'(mark_cur);
    assign idx_ext  = CW'(idx_reg);
    assign link_waddr = AW'(pidx_reg) * REC_STEP + AW'(idx_ext[RIW-1:0]);

    always_comb
    begin
        rsp_data_next.granted_index = '0;
        rsp_data_next.status        = ST_OK;
        pool_we    = 1'b0;
        head_next  = head_cur;
        mark_next  = mark_cur;
        link_we    = 1'b0;
        if (!pool_ok_reg)
        begin
            rsp_data_next.status = (mode_reg == MODE_ALLOC) ? ST_EXHAUSTED : ST_BAD_INDEX;
        end
        else if (mode_reg == MODE_ALLOC)
        begin
            if (head_cur == mark_cur)
            begin
                if (mark_cur >= REC_LIM)
                begin
                    rsp_data_next.status = ST_EXHAUSTED;
                end
                else
                begin
                    rsp_data_next.granted_index = head_ext[IDX_W-1:0];
                    pool_we   = commit;
                    head_next = head_cur + 1'b1;
                    mark_next = head_cur + 1'b1;
                end
            end
            else if (head_cur < REC_LIM)
            begin
                rsp_data_next.granted_index = head_ext[IDX_W-1:0];
                pool_we   = commit;
                head_next = link_rd_reg;
            end
            else
            begin
                rsp_data_next.status = ST_EXHAUSTED;
            end
        end
        else
        begin
            if (idx_ext >= mark_ext || idx_ext >= REC_LIM_C)
            begin
                rsp_data_next.status = ST_BAD_INDEX;
            end
            else
            begin
                pool_we   = commit;
                link_we   = commit;
                head_next = idx_ext[HW-1:0];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // per-pool head and high-water mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POOLS; i++)
            begin
                free_head_reg[i]  <= '0;
                high_water_reg[i] <= '0;
            end
        end
        else if (pool_we)
        begin
            free_head_reg[pidx_reg]  <= head_next;
            high_water_reg[pidx_reg] <= mark_next;
        end
    end

    // request capture and response payload
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            mode_reg    <= req.payload.mode;
            pool_ok_reg <= pool_ok_in;
            pidx_reg    <= pidx_in;
            idx_reg     <= req.payload.freed_index;
        end
        if (commit)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    // link memory
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= head_cur;
        end
        if (link_re)
        begin
            link_rd_reg <= link_mem[link_raddr];
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

    a_mark_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) && pool_ok_reg |-> mark_cur <= REC_LIM)
        else $error("high-water mark beyond pool capacity");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) && pool_ok_reg |-> head_cur <= mark_cur)
        else $error("free head above high-water mark");

    a_commit_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> rsp_valid_reg && (state_reg == S_IDLE))
        else $error("commit did not produce a response");

    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        link_we |-> (mode_reg == MODE_FREE) && (rsp_data_next.status == ST_OK))
        else $error("link written on a failed or non-free request");

endmodule
